### rtl/core/zild_pkg.sv
// Types, opcode constants and length tables for the Z80N instruction length decoder.
// No dependencies; used by every module of the core.
`default_nettype none

package zild_pkg;

  localparam logic [7:0] OP_CB = 8'hCB;
  localparam logic [7:0] OP_ED = 8'hED;
  localparam logic [7:0] OP_DD = 8'hDD;
  localparam logic [7:0] OP_FD = 8'hFD;

  localparam logic [7:0] MASK_RST  = 8'hC7;
  localparam logic [7:0] MASK_PUSH = 8'hCF;

  localparam logic [7:0] ED_NEXTREG_NN = 8'h91;
  localparam logic [7:0] ED_NEXTREG_A  = 8'h92;
  localparam logic [7:0] ED_PUSH_NN    = 8'h8A;
  localparam logic [7:0] ED_TEST_N     = 8'h27;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_CB,
    PFX_ED,
    PFX_IDX
  } prefix_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] length_bytes;
    logic       second_used;
  } result_t;

  typedef struct packed {
    prefix_t    prefix;
    logic [2:0] len_ed;
    logic [2:0] len_idx;
    logic [2:0] len_plain;
  } lookup_t;

  function automatic prefix_t classify(input logic [7:0] b);
    prefix_t p;
    p = PFX_NONE;
    if (b == OP_CB) begin
      p = PFX_CB;
    end else if (b == OP_ED) begin
      p = PFX_ED;
    end else if (b == OP_DD || b == OP_FD) begin
      p = PFX_IDX;
    end
    return p;
  endfunction

  function automatic logic [2:0] len_after_ed(input logic [7:0] b);
    logic [2:0] len;
    case (b)
      8'h43, 8'h4B, 8'h53, 8'h5B,
      8'h63, 8'h6B, 8'h73, 8'h7B,
      ED_NEXTREG_NN,
      8'h34, 8'h35, 8'h36,
      ED_PUSH_NN:               len = LEN_4;
      ED_NEXTREG_A, ED_TEST_N:  len = LEN_3;
      default:                  len = LEN_2;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] len_after_index(input logic [7:0] b);
    logic [2:0] len;
    case (b)
      OP_CB, 8'h21, 8'h22, 8'h2A, 8'h36: len = LEN_4;
      8'h26, 8'h2E, 8'h34, 8'h35,
      8'h46, 8'h4E, 8'h56, 8'h5E,
      8'h66, 8'h6E, 8'h7E,
      8'h70, 8'h71, 8'h72, 8'h73,
      8'h74, 8'h75, 8'h77,
      8'h86, 8'h8E, 8'h96, 8'h9E,
      8'hA6, 8'hAE, 8'hB6, 8'hBE:        len = LEN_3;
      default:                           len = LEN_2;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] len_plain(input logic [7:0] b);
    logic [2:0] len;
    case (b)
      8'h06, 8'h0E, 8'h16, 8'h1E,
      8'h26, 8'h2E, 8'h36, 8'h3E,
      8'hC6, 8'hCE, 8'hD6, 8'hDE,
      8'hE6, 8'hEE, 8'hF6, 8'hFE,
      8'hD3, 8'hDB,
      8'h10, 8'h18,
      8'h20, 8'h28, 8'h30, 8'h38:        len = LEN_2;
      8'h01, 8'h11, 8'h21, 8'h31,
      8'h22, 8'h2A, 8'h32, 8'h3A,
      8'hC2, 8'hC3, 8'hCA, 8'hD2, 8'hDA,
      8'hE2, 8'hEA, 8'hF2, 8'hFA,
      8'hC4, 8'hCC, 8'hCD, 8'hD4, 8'hDC,
      8'hE4, 8'hEC, 8'hF4, 8'hFC:        len = LEN_3;
      default:                           len = LEN_1;
    endcase
    if (b >= 8'h40 && b <= 8'hBF) begin
      len = LEN_1;
    end
    if ((b & MASK_RST) == 8'hC0 || (b & MASK_RST) == 8'hC7) begin
      len = LEN_1;
    end
    if ((b & MASK_PUSH) == 8'hC1 || (b & MASK_PUSH) == 8'hC5) begin
      len = LEN_1;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/core/zild_lookup.sv
// Table lookup stage: prefix class and the three candidate lengths.
// Depends on zild_pkg.
`default_nettype none

module zild_lookup import zild_pkg::*; (
  input  item_t   item,
  output lookup_t lookup
);

  always_comb begin
    lookup.prefix    = classify(item.first_byte);
    lookup.len_ed    = len_after_ed(item.second_byte);
    lookup.len_idx   = len_after_index(item.second_byte);
    lookup.len_plain = len_plain(item.first_byte);
  end

endmodule

`default_nettype wire

### rtl/core/zild_select.sv
// Select stage: picks the final length and second-byte flag by prefix class.
// Depends on zild_pkg.
`default_nettype none

module zild_select import zild_pkg::*; (
  input  lookup_t lookup,
  output result_t result
);

  always_comb begin
    case (lookup.prefix)
      PFX_CB: begin
        result.length_bytes = LEN_2;
        result.second_used  = 1'b0;
      end
      PFX_ED: begin
        result.length_bytes = lookup.len_ed;
        result.second_used  = 1'b1;
      end
      PFX_IDX: begin
        result.length_bytes = lookup.len_idx;
        result.second_used  = 1'b1;
      end
      default: begin
        result.length_bytes = lookup.len_plain;
        result.second_used  = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/z80n_instruction_length_decode_core.sv
// Top level of the Z80N instruction length decoder: three-stage pipeline.
// Depends on zild_pkg, zild_lookup and zild_select.
//
// Takes the first two bytes fetched at an instruction address and returns the
// instruction length (1 to 4 bytes, prefixes and operands included) and a flag
// that is set when the second byte decided the result (ED, DD or FD prefix).
// One transfer per cycle is accepted while the output is not stalled. The
// stages are an input register, a register after the opcode table lookup and
// the output register, and each result passes through them in that order;
// each stage holds its own valid bit, so a stalled output only backs up the
// stages behind it once they are full.
`default_nettype none

module z80n_instruction_length_decode_core import zild_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic    v1, v2, v3;
  logic    en1, en2, en3;
  item_t   s1;
  lookup_t s2;
  result_t s3;
  lookup_t lookup_next;
  result_t result_next;

  assign en3 = !v3 || !result_stall;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign item_stall   = !en1;
  assign result_valid = v3;
  assign result       = s3;

  zild_lookup u_lookup (
    .item   (s1),
    .lookup (lookup_next)
  );

  zild_select u_select (
    .lookup (s2),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= item_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= item;
    end
    if (en2) begin
      s2 <= lookup_next;
    end
    if (en3) begin
      s3 <= result_next;
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.length_bytes >= LEN_1 && result.length_bytes <= LEN_4))
    else $error("length out of range");

  a_plain_max3: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.second_used |-> result.length_bytes <= LEN_3)
    else $error("unprefixed length above 3");

  a_prefixed_min2: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.second_used |-> result.length_bytes >= LEN_2)
    else $error("prefixed length below 2");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !en2 |=> v2 && $stable(s2))
    else $error("stalled lookup stage lost its item");

endmodule

`default_nettype wire
